// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// ante holds in a cycle -> cons holds in the same cycle
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// ante holds in a cycle -> cons holds in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- rtl/core/wcd_pkg.sv -----
// ----------------------------------------------------------------------------
// wcd_pkg
// Constants, control word types and microcode ROM of the column decimator.
// ----------------------------------------------------------------------------
package wcd_pkg;

  localparam int MAX_COLUMNS     = 1024;
  localparam int MAX_RUN         = 64;
  localparam int PHASE_FRAC_BITS = 16;

  localparam int SAMPLE_W = 16;
  localparam int SLOT_W   = 11;
  localparam int CCNT_W   = 11;
  localparam int PINC_W   = 22;
  localparam int PHASE_W  = PHASE_FRAC_BITS + 2;
  localparam int POS_W    = SLOT_W + PHASE_FRAC_BITS + 1;
  localparam int RUN_W    = $clog2(MAX_RUN);
  localparam int DCNT_W   = $clog2(SAMPLE_W);

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam int OUT_DW = 32;

  localparam logic [PINC_W-1:0] INC_LIMIT = PINC_W'((MAX_RUN - 1) << PHASE_FRAC_BITS);
  localparam logic [PINC_W-1:0] INC_TWO   = PINC_W'(2 << PHASE_FRAC_BITS);
  localparam logic [CCNT_W-1:0] CCNT_MAX  = CCNT_W'(MAX_COLUMNS);

  // register indexes (paddr[2])
  localparam logic REG_COLUMN_COUNT    = 1'b0;
  localparam logic REG_PHASE_INCREMENT = 1'b1;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_ISETUP,
    OP_DIVSTEP,
    OP_DIVFIX,
    OP_IEMIT,
    OP_IDONE,
    OP_MINMAX,
    OP_PEMIT,
    OP_PDONE,
    OP_MIDPT
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_MINMAX,
    C_MID,
    C_DIV_MORE,
    C_OUT_MORE,
    C_NO_PAIR
  } cond_t;

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   tgt;
  } uword_t;

  // program addresses
  localparam pc_t P_WAIT  = 4'd0;
  localparam pc_t P_DISP  = 4'd1;
  localparam pc_t P_DISP2 = 4'd2;
  localparam pc_t P_ISET  = 4'd3;
  localparam pc_t P_IDIV  = 4'd4;
  localparam pc_t P_IFIX  = 4'd5;
  localparam pc_t P_IEMIT = 4'd6;
  localparam pc_t P_IDONE = 4'd7;
  localparam pc_t P_MM    = 4'd8;
  localparam pc_t P_PEMIT = 4'd9;
  localparam pc_t P_PDONE = 4'd10;
  localparam pc_t P_MID   = 4'd11;

  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    unique case (pc)
      P_WAIT:  w = '{op: OP_LOAD,    cond: C_NO_IN,    tgt: P_WAIT};
      P_DISP:  w = '{op: OP_NOP,     cond: C_MINMAX,   tgt: P_MM};
      P_DISP2: w = '{op: OP_NOP,     cond: C_MID,      tgt: P_MID};
      P_ISET:  w = '{op: OP_ISETUP,  cond: C_NEVER,    tgt: P_WAIT};
      P_IDIV:  w = '{op: OP_DIVSTEP, cond: C_DIV_MORE, tgt: P_IDIV};
      P_IFIX:  w = '{op: OP_DIVFIX,  cond: C_NEVER,    tgt: P_WAIT};
      P_IEMIT: w = '{op: OP_IEMIT,   cond: C_OUT_MORE, tgt: P_IEMIT};
      P_IDONE: w = '{op: OP_IDONE,   cond: C_ALWAYS,   tgt: P_WAIT};
      P_MM:    w = '{op: OP_MINMAX,  cond: C_NO_PAIR,  tgt: P_WAIT};
      P_PEMIT: w = '{op: OP_PEMIT,   cond: C_OUT_MORE, tgt: P_PEMIT};
      P_PDONE: w = '{op: OP_PDONE,   cond: C_ALWAYS,   tgt: P_WAIT};
      P_MID:   w = '{op: OP_MIDPT,   cond: C_ALWAYS,   tgt: P_PEMIT};
      default: w = '{op: OP_NOP,     cond: C_ALWAYS,   tgt: P_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/core/waveform_column_decimator.sv -----
// ----------------------------------------------------------------------------
// waveform_column_decimator
// Min/max peak decimation of an audio stream onto 2*column_count display
// slots; every result word is one slot write. Control runs from a small
// microcode ROM (step counter, conditional jumps) over a shared datapath, one
// sample at a time; a new sample is accepted only after the last one is done.
// Min/max mode writes nothing while the column stays open and two slots when
// it closes; exact-2 mode writes two slots; interpolation mode runs a
// bit-serial restoring divider that splits the sample difference by the run
// length, then writes 3 to 64 slots. Writes wait on output stalls. A register
// write clears the model state but not the sequencer, and takes effect at once.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module waveform_column_decimator (
  input  logic                        clk,
  input  logic                        rst_n,
  // sample stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [wcd_pkg::SAMPLE_W-1:0] in_tdata,   // [15:0] sample
  // slot write stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [wcd_pkg::OUT_DW-1:0]  out_tdata,   // [10:0] slot, [26:11] value
  output logic                        out_tlast,
  // configuration
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [wcd_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [wcd_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [wcd_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import wcd_pkg::*;

  // config
  logic [CCNT_W-1:0] colcnt_r;
  logic [PINC_W-1:0] phinc_r;
  // architectural state
  logic [SLOT_W-1:0]          wslot_r, wslot_nxt;
  logic [PHASE_W-1:0]         phase_r, phase_nxt;
  logic [SLOT_W-1:0]          pos_int_r, pos_int_nxt;
  logic [PHASE_FRAC_BITS-1:0] pos_frac_r, pos_frac_nxt;
  logic signed [SAMPLE_W-1:0] cmin_r, cmin_nxt, cmax_r, cmax_nxt;
  logic                       mfirst_r, mfirst_nxt, cempty_r, cempty_nxt;
  logic signed [SAMPLE_W-1:0] prev_r, prev_nxt;
  // working registers
  pc_t                        pc_r, pc_nxt;
  logic signed [SAMPLE_W-1:0] x_r, x_nxt;
  logic [SLOT_W-1:0]          slot_r, slot_nxt;
  logic signed [SAMPLE_W-1:0] v_r, v_nxt, vb_r, vb_nxt;
  logic [RUN_W-1:0]           i_r, i_nxt, n_r, n_nxt;
  logic [RUN_W-1:0]           dvs_r, dvs_nxt;
  logic [SAMPLE_W-1:0]        dq_r, dq_nxt;
  logic [RUN_W-1:0]           rem_r, rem_nxt;
  logic [DCNT_W-1:0]          dcnt_r, dcnt_nxt;
  logic                       neg_r, neg_nxt;
  logic signed [SAMPLE_W:0]   qd_r, qd_nxt;
  logic [RUN_W:0]             rm2_r, rm2_nxt, span2_r, span2_nxt;
  logic [RUN_W+1:0]           racc_r, racc_nxt;

  uword_t uw;
  logic   in_fire, out_fire, emit_last, cfg_wr, jump;

  // derived config
  logic [CCNT_W-1:0] ccnt_eff;
  logic [SLOT_W-1:0] slot_last;
  logic [PINC_W-1:0] inc_eff;
  logic              mode_mm, mode_mid;

  assign ccnt_eff  = (colcnt_r == '0) ? CCNT_W'(1) :
                     (colcnt_r > CCNT_MAX) ? CCNT_MAX : colcnt_r;
  assign slot_last = SLOT_W'({ccnt_eff, 1'b0} - (CCNT_W+1)'(1));
  assign inc_eff   = (phinc_r > INC_LIMIT) ? INC_LIMIT : phinc_r;
  assign mode_mm   = inc_eff < INC_TWO;
  assign mode_mid  = inc_eff == INC_TWO;

  function automatic logic [SLOT_W-1:0] wrap_inc(input logic [SLOT_W-1:0] s,
                                                 input logic [SLOT_W-1:0] lst);
    return (s == lst) ? '0 : s + SLOT_W'(1);
  endfunction

  assign uw        = ucode(pc_r);
  assign in_tready = (uw.op == OP_LOAD);
  assign in_fire   = in_tvalid && in_tready;
  assign out_tvalid = (uw.op == OP_IEMIT) || (uw.op == OP_PEMIT);
  assign out_fire  = out_tvalid && out_tready;
  assign emit_last = (i_r == n_r);
  assign out_tlast = emit_last;
  assign out_tdata = {{(OUT_DW-SLOT_W-SAMPLE_W){1'b0}}, v_r, slot_r};

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_PHASE_INCREMENT) ?
                      CFG_DW'(phinc_r) : CFG_DW'(colcnt_r);

  // datapath helpers
  logic [PHASE_W-1:0]        phase_sum;
  logic [POS_W-1:0]          pos_sum;
  logic [RUN_W-1:0]          span_raw;
  logic signed [SAMPLE_W:0]  diff, msum;
  logic [RUN_W:0]            dshift;
  logic                      dge;
  logic [RUN_W+1:0]          racc_sum;
  logic                      rcarry;
  logic signed [SAMPLE_W+1:0] v_step;

  assign phase_sum = phase_r + inc_eff[PHASE_W-1:0];
  assign pos_sum   = {1'b0, pos_int_r, pos_frac_r} + POS_W'(inc_eff);
  assign span_raw  = RUN_W'(pos_sum[POS_W-1:PHASE_FRAC_BITS] - {1'b0, pos_int_r});
  assign diff      = {x_r[SAMPLE_W-1], x_r} - {prev_r[SAMPLE_W-1], prev_r};
  assign msum      = {x_r[SAMPLE_W-1], x_r} + {prev_r[SAMPLE_W-1], prev_r};
  assign dshift    = {rem_r, dq_r[SAMPLE_W-1]};
  assign dge       = dshift >= {1'b0, dvs_r};
  assign racc_sum  = racc_r + {1'b0, rm2_r};
  assign rcarry    = racc_sum >= {1'b0, span2_r};
  assign v_step    = {{2{v_r[SAMPLE_W-1]}}, v_r} + {qd_r[SAMPLE_W], qd_r}
                     + (SAMPLE_W+2)'(rcarry);

  // sequencer
  always_comb begin
    unique case (uw.cond)
      C_NEVER:    jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_NO_IN:    jump = !in_fire;
      C_MINMAX:   jump = mode_mm;
      C_MID:      jump = mode_mid;
      C_DIV_MORE: jump = (dcnt_r != '0);
      C_OUT_MORE: jump = !(out_fire && emit_last);
      C_NO_PAIR:  jump = (phase_sum < INC_TWO[PHASE_W-1:0]);
      default:    jump = 1'b0;
    endcase
    pc_nxt = jump ? uw.tgt : pc_r + PC_W'(1);
  end

  // datapath
  always_comb begin
    logic signed [SAMPLE_W-1:0] mn, mx;
    logic                       mf;
    logic [SAMPLE_W:0]          qmag;
    logic [RUN_W-1:0]           rm;
    wslot_nxt = wslot_r;   phase_nxt = phase_r;
    pos_int_nxt = pos_int_r; pos_frac_nxt = pos_frac_r;
    cmin_nxt = cmin_r;     cmax_nxt = cmax_r;
    mfirst_nxt = mfirst_r; cempty_nxt = cempty_r;
    prev_nxt = prev_r;     x_nxt = x_r;
    slot_nxt = slot_r;     v_nxt = v_r;      vb_nxt = vb_r;
    i_nxt = i_r;           n_nxt = n_r;      dvs_nxt = dvs_r;
    dq_nxt = dq_r;         rem_nxt = rem_r;  dcnt_nxt = dcnt_r;
    neg_nxt = neg_r;       qd_nxt = qd_r;    rm2_nxt = rm2_r;
    span2_nxt = span2_r;   racc_nxt = racc_r;
    mn = cmin_r; mx = cmax_r; mf = mfirst_r;
    qmag = {1'b0, dq_r};
    rm = rem_r;
    case (uw.op)
      OP_LOAD: begin
        if (in_fire) x_nxt = in_tdata;
      end
      OP_ISETUP: begin
        pos_frac_nxt = pos_sum[PHASE_FRAC_BITS-1:0];
        slot_nxt = pos_int_r;
        n_nxt    = span_raw;
        i_nxt    = '0;
        dvs_nxt  = (span_raw == '0) ? RUN_W'(1) : span_raw;
        neg_nxt  = diff[SAMPLE_W];
        dq_nxt   = diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];
        rem_nxt  = '0;
        dcnt_nxt = DCNT_W'(SAMPLE_W - 1);
      end
      OP_DIVSTEP: begin
        rem_nxt  = dge ? RUN_W'(dshift - {1'b0, dvs_r}) : dshift[RUN_W-1:0];
        dq_nxt   = {dq_r[SAMPLE_W-2:0], dge};
        dcnt_nxt = dcnt_r - DCNT_W'(1);
      end
      OP_DIVFIX: begin
        // floor division of a negative difference
        if (neg_r && rem_r != '0) begin
          qd_nxt = -$signed(qmag) - (SAMPLE_W+1)'(1);
          rm     = dvs_r - rem_r;
        end else if (neg_r) begin
          qd_nxt = -$signed(qmag);
        end else begin
          qd_nxt = $signed(qmag);
        end
        rm2_nxt   = {rm, 1'b0};
        span2_nxt = {dvs_r, 1'b0};
        racc_nxt  = (RUN_W+2)'(dvs_r);
        v_nxt     = prev_r;
      end
      OP_IEMIT: begin
        if (out_fire && !emit_last) begin
          slot_nxt = wrap_inc(slot_r, slot_last);
          i_nxt    = i_r + RUN_W'(1);
          v_nxt    = v_step[SAMPLE_W-1:0];
          racc_nxt = rcarry ? racc_sum - {1'b0, span2_r} : racc_sum;
        end
      end
      OP_IDONE: begin
        wslot_nxt   = wrap_inc(slot_r, slot_last);
        pos_int_nxt = slot_r;
        prev_nxt    = x_r;
      end
      OP_MINMAX: begin
        if (cempty_r) begin
          mn = x_r; mx = x_r; mf = 1'b0;
        end else begin
          if (x_r < cmin_r) begin
            mn = x_r; mf = 1'b0;
          end
          if (x_r > cmax_r) begin
            mx = x_r; mf = 1'b1;
          end
        end
        cmin_nxt = mn; cmax_nxt = mx; mfirst_nxt = mf;
        prev_nxt = x_r;
        slot_nxt = wslot_r;
        i_nxt    = '0;
        n_nxt    = RUN_W'(1);
        v_nxt    = mf ? mn : mx;
        vb_nxt   = mf ? mx : mn;
        if (phase_sum >= INC_TWO[PHASE_W-1:0]) begin
          phase_nxt  = phase_sum - INC_TWO[PHASE_W-1:0];
          cempty_nxt = 1'b1;
        end else begin
          phase_nxt  = phase_sum;
          cempty_nxt = 1'b0;
        end
      end
      OP_MIDPT: begin
        slot_nxt = wslot_r;
        i_nxt    = '0;
        n_nxt    = RUN_W'(1);
        v_nxt    = msum[SAMPLE_W:1];
        vb_nxt   = x_r;
        prev_nxt = x_r;
      end
      OP_PEMIT: begin
        if (out_fire && !emit_last) begin
          slot_nxt = wrap_inc(slot_r, slot_last);
          i_nxt    = i_r + RUN_W'(1);
          v_nxt    = vb_r;
        end
      end
      OP_PDONE: begin
        wslot_nxt = wrap_inc(slot_r, slot_last);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r     <= P_WAIT;
      colcnt_r <= CCNT_W'(1);
      phinc_r  <= PINC_W'(30);
    end else begin
      pc_r <= pc_nxt;
      if (cfg_wr && cfg_paddr[2] == REG_COLUMN_COUNT) colcnt_r <= cfg_pwdata[CCNT_W-1:0];
      if (cfg_wr && cfg_paddr[2] == REG_PHASE_INCREMENT) phinc_r <= cfg_pwdata[PINC_W-1:0];
    end
  end

  // model state: cleared by reset and by any register write
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) begin
      wslot_r    <= '0;
      phase_r    <= '0;
      pos_int_r  <= '0;
      pos_frac_r <= '0;
      cmin_r     <= '0;
      cmax_r     <= '0;
      mfirst_r   <= 1'b0;
      cempty_r   <= 1'b1;
      prev_r     <= '0;
    end else begin
      wslot_r    <= wslot_nxt;
      phase_r    <= phase_nxt;
      pos_int_r  <= pos_int_nxt;
      pos_frac_r <= pos_frac_nxt;
      cmin_r     <= cmin_nxt;
      cmax_r     <= cmax_nxt;
      mfirst_r   <= mfirst_nxt;
      cempty_r   <= cempty_nxt;
      prev_r     <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    slot_r  <= slot_nxt;
    v_r     <= v_nxt;
    vb_r    <= vb_nxt;
    i_r     <= i_nxt;
    n_r     <= n_nxt;
    dvs_r   <= dvs_nxt;
    dq_r    <= dq_nxt;
    rem_r   <= rem_nxt;
    dcnt_r  <= dcnt_nxt;
    neg_r   <= neg_nxt;
    qd_r    <= qd_nxt;
    rm2_r   <= rm2_nxt;
    span2_r <= span2_nxt;
    racc_r  <= racc_nxt;
  end

  `ASSERT_IMPL(a_no_intake_while_emit, clk, rst_n, out_tvalid, !in_tready)
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_fire, !in_tready)
  `ASSERT_NEXT(a_valid_drops_after_last, clk, rst_n, out_fire && out_tlast, !out_tvalid)
  `ASSERT_IMPL(a_interp_rem_bound, clk, rst_n, uw.op == OP_IEMIT, racc_r < {1'b0, span2_r})

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the waveform column decimator: samples go in on the input
// stream, every slot write on the result stream is compared with a local
// predictor (min/max, exact-two and interpolation modes), with random idles
// on both sides, a long output hold-off and several register settings.
// ----------------------------------------------------------------------------
module tb_top;
  import wcd_pkg::*;

  localparam int SETTLE_CYCLES = 120;   // longer than one sample's busy time
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 3000;
  localparam int VALUE_LSB     = SLOT_W;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic [SAMPLE_W-1:0] value;
    logic                last;
  } slot_write_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [SAMPLE_W-1:0] in_tdata;     // [15:0] sample
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_DW-1:0]   out_tdata;    // [10:0] slot, [26:11] value
  logic                out_tlast;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CFG_AW-1:0]   cfg_paddr;
  logic [CFG_DW-1:0]   cfg_pwdata;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  waveform_column_decimator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // predictor state
  logic [CCNT_W-1:0]  reg_columns;
  logic [PINC_W-1:0]  reg_increment;
  logic [SLOT_W-1:0]  wr_slot;
  logic [PHASE_W-1:0] col_phase;
  logic [27:0]        interp_pos;
  int                 col_min;
  int                 col_max;
  int                 prev_sample;
  bit                 min_first;
  bit                 col_empty;

  slot_write_t expected_writes[$];
  int          mismatch_count;
  int          stall_cycles;
  bit          no_idle;
  bit          hold_req;
  logic [15:0] last_sent;

  function automatic void clear_decimator();
    wr_slot     = '0;
    col_phase   = '0;
    interp_pos  = '0;
    col_min     = 0;
    col_max     = 0;
    min_first   = 1'b0;
    col_empty   = 1'b1;
    prev_sample = 0;
  endfunction

  function automatic void push_write(input logic [SLOT_W-1:0] at_slot,
                                     input logic [SAMPLE_W-1:0] data, input logic is_end);
    expected_writes.push_back('{slot: at_slot, value: data, last: is_end});
  endfunction

  function automatic void decimate_sample(input logic [SAMPLE_W-1:0] raw);
    int unsigned slots, run_start, run_end, span, num, q, i;
    logic [PINC_W-1:0] inc;
    logic [PHASE_FRAC_BITS-1:0] frac;
    int x, diff, v, mid;
    if (reg_columns == '0) slots = 2;
    else if (reg_columns > CCNT_MAX) slots = 2 * MAX_COLUMNS;
    else slots = 2 * int'(reg_columns);
    inc = (reg_increment > INC_LIMIT) ? INC_LIMIT : reg_increment;
    x = int'($signed(raw));
    wr_slot = SLOT_W'(wr_slot % slots);
    if (inc < INC_TWO) begin
      if (col_empty) begin
        col_min   = x;
        col_max   = x;
        min_first = 1'b0;
        col_empty = 1'b0;
      end else begin
        if (x < col_min) begin
          col_min   = x;
          min_first = 1'b0;
        end
        if (x > col_max) begin
          col_max   = x;
          min_first = 1'b1;
        end
      end
      col_phase = col_phase + PHASE_W'(inc);
      if (col_phase >= PHASE_W'(INC_TWO)) begin
        push_write(wr_slot, SAMPLE_W'(min_first ? col_min : col_max), 1'b0);
        push_write(SLOT_W'((wr_slot + 1) % slots),
                   SAMPLE_W'(min_first ? col_max : col_min), 1'b1);
        wr_slot   = SLOT_W'((wr_slot + 2) % slots);
        col_phase = col_phase - PHASE_W'(INC_TWO);
        col_empty = 1'b1;
      end
    end else if (inc > INC_TWO) begin
      run_start  = interp_pos >> PHASE_FRAC_BITS;
      diff       = x - prev_sample;
      interp_pos = interp_pos + 28'(inc);
      run_end    = interp_pos >> PHASE_FRAC_BITS;
      span       = run_end - run_start;
      if (span == 0) span = 1;
      for (i = 0; run_start + i <= run_end && i < MAX_RUN; i++) begin
        // offset keeps the numerator nonnegative; round half up
        num = $unsigned(diff + 65535) * i + 65535 * (span - i);
        q   = (2 * num + span) / (2 * span);
        v   = prev_sample + int'(q) - 65535;
        push_write(SLOT_W'((run_start + i) % slots), SAMPLE_W'(v), run_start + i == run_end);
      end
      wr_slot    = SLOT_W'((run_end + 1) % slots);
      frac       = interp_pos[PHASE_FRAC_BITS-1:0];
      interp_pos = 28'((run_end % slots) << PHASE_FRAC_BITS) | 28'(frac);
    end else begin
      mid = (x + prev_sample) >>> 1;    // floor of the mean
      push_write(wr_slot, SAMPLE_W'(mid), 1'b0);
      push_write(SLOT_W'((wr_slot + 1) % slots), raw, 1'b1);
      wr_slot = SLOT_W'((wr_slot + 2) % slots);
    end
    prev_sample = x;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0d expected %0d (t=%0t)", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // result side: random stalls, plus a long hold-off on request
  initial begin : result_sink
    int hold_left;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        hold_left  = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= no_idle || ($urandom_range(99) >= 18);
      end
    end
  end

  always @(posedge clk) begin : write_checker
    slot_write_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_writes.size() == 0) begin
        report_mismatch("unexpected write to slot", int'(out_tdata[SLOT_W-1:0]), -1);
      end else begin
        want = expected_writes.pop_front();
        if (out_tdata[SLOT_W-1:0] != want.slot)
          report_mismatch("slot", int'(out_tdata[SLOT_W-1:0]), int'(want.slot));
        if (out_tdata[VALUE_LSB +: SAMPLE_W] != want.value)
          report_mismatch("value", int'($signed(out_tdata[VALUE_LSB +: SAMPLE_W])),
                          int'($signed(want.value)));
        if (out_tlast != want.last)
          report_mismatch("last", int'(out_tlast), int'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // valid stays high between back-to-back words; lowered only in gaps
  task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
    while (!no_idle && $urandom_range(99) < 18) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sample;
    do @(posedge clk); while (!in_tready);
    last_sent = sample;
    decimate_sample(sample);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_writes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic reg_index, input logic [CFG_DW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_index, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (reg_index == REG_COLUMN_COUNT) reg_columns = data[CCNT_W-1:0];
    else reg_increment = data[PINC_W-1:0];
    clear_decimator();
    @(posedge clk);
  endtask

  task automatic set_mode(input logic [CFG_DW-1:0] columns, input logic [CFG_DW-1:0] increment);
    settle();
    write_register(REG_COLUMN_COUNT, columns);
    write_register(REG_PHASE_INCREMENT, increment);
  endtask

  function automatic logic [15:0] pick_sample(input logic [15:0] near);
    case ($urandom_range(5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return near + 16'($urandom_range(64)) - 16'd32;
      default: return 16'($urandom);
    endcase
  endfunction

  // reset config is 1 column at a tiny increment: no column can close yet
  task automatic test_reset_defaults();
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0000);
  endtask

  // column count zero acts as one; extremes in both orders
  task automatic test_minmax_extremes();
    set_mode(32'd0, 32'h0000_8000);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h0000);
    send_sample(16'h0001);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'hFFFF);
    send_sample(16'h0002);
  endtask

  // equal extremes and one-sample columns write the max first
  task automatic test_minmax_ties();
    set_mode(32'd2, 32'h0001_FFFF);
    send_sample(16'h0005);
    send_sample(16'h0005);
    send_sample(16'h0005);
    send_sample(16'hFFFB);
  endtask

  task automatic test_exact_two();
    set_mode(32'd1024, 32'(INC_TWO));
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
  endtask

  // saturated increment gives the longest runs; oversized column count
  task automatic test_interp_saturated();
    set_mode(32'd2047, 32'h003F_FFFF);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h1234);
  endtask

  task automatic test_zero_increment();
    set_mode(32'd3, 32'd0);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
  endtask

  task automatic test_output_hold();
    int n;
    set_mode(32'd16, 32'h0005_4000);
    hold_req = 1'b1;
    for (n = 0; n < 20; n++) send_sample(pick_sample(last_sent));
  endtask

  task automatic test_random_phases();
    logic [CFG_DW-1:0] columns;
    logic [CFG_DW-1:0] increment;
    int phase, n;
    for (phase = 0; phase < 8; phase++) begin
      case ($urandom_range(6))
        0:       columns = 32'd0;
        1:       columns = 32'd1;
        2:       columns = 32'd1024;
        3:       columns = 32'd2047;
        default: columns = $urandom_range(2047);
      endcase
      case (phase % 4)
        0: increment = $urandom_range(32'h0000_2000, 32'h0001_FFFF);
        1: increment = $urandom_range(32'h0002_0001, 32'h0008_0000);
        2: increment = (phase == 2) ? 32'(INC_TWO) : $urandom_range(32'h0002_0001, 32'h003F_FFFF);
        default: increment = $urandom_range(32'h003F_FFFF);
      endcase
      no_idle = (phase == 5);
      set_mode(columns, increment);
      for (n = 0; n < 46; n++) send_sample(pick_sample(last_sent));
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    mismatch_count = 0;
    stall_cycles   = 0;
    no_idle        = 1'b0;
    hold_req       = 1'b0;
    last_sent      = '0;
    reg_columns    = CCNT_W'(1);
    reg_increment  = PINC_W'(30);
    clear_decimator();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_minmax_extremes();
    test_minmax_ties();
    test_exact_two();
    test_interp_saturated();
    test_zero_increment();
    test_output_hold();
    test_random_phases();
    settle();

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/wcd_pkg.sv
rtl/core/waveform_column_decimator.sv
dv/tb_top.sv
